FILE: hdl/mffhf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mffhf_pkg;

   // byte counter width; the count saturates at its maximum
   localparam int COUNT_BITS = 32;
   // scan limit: 10 + 28-bit tag size + 4 fits in 29 bits
   localparam int LIM_BITS = 29;
   localparam int CMP_BITS = (COUNT_BITS > LIM_BITS) ? COUNT_BITS : LIM_BITS;

   localparam int TAG_HDR_LEN = 10;
   localparam int MIN_LEN = 10;
   localparam int WIN_LEN = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [2:0] SYNC_TOP = 3'b111;
   localparam logic [1:0] LAYER_III_CODE = 2'b01;
   localparam logic [1:0] MPEG1_CODE = 2'b11;
   localparam logic [23:0] ID3_MAGIC = 24'h494433;

   // tag header byte offsets
   localparam int POS_MAGIC_END = 2;
   localparam int POS_VERSION = 3;
   localparam int POS_SIZE_FIRST = 6;
   localparam int POS_SIZE_LAST = 9;

   // one file summary as handed from the scanner to the decoder
   typedef struct packed {
      logic call_ok;
      logic has_tag;
      logic [7:0] tag_version;
      logic [27:0] tag_size;
      logic frame_found;
      logic [23:0] header;   // header bytes 1..3
      logic [31:0] file_length;
   } summary_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [8:0] kbps_lookup(input logic [3:0] idx);
      logic [8:0] kbps;
      case (idx)
         4'd1: kbps = 9'd32;
         4'd2: kbps = 9'd40;
         4'd3: kbps = 9'd48;
         4'd4: kbps = 9'd56;
         4'd5: kbps = 9'd64;
         4'd6: kbps = 9'd80;
         4'd7: kbps = 9'd96;
         4'd8: kbps = 9'd112;
         4'd9: kbps = 9'd128;
         4'd10: kbps = 9'd160;
         4'd11: kbps = 9'd192;
         4'd12: kbps = 9'd224;
         4'd13: kbps = 9'd256;
         4'd14: kbps = 9'd320;
         default: kbps = 9'd0;
      endcase
      return kbps;
   endfunction

   function automatic logic [15:0] rate_lookup(input logic [1:0] idx);
      logic [15:0] rate;
      case (idx)
         2'd0: rate = 16'd44100;
         2'd1: rate = 16'd48000;
         2'd2: rate = 16'd32000;
         default: rate = 16'd0;
      endcase
      return rate;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/mffhf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mffhf_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic accept,
   input  wire logic [7:0] data_byte,
   input  wire logic last_byte,
   output logic push,
   output mffhf_pkg::summary_type rec
);
   import mffhf_pkg::*;

   logic [COUNT_BITS-1:0] pos_ff, pos_in;
   logic [31:0] window_ff, window_in;
   logic tag_ff, tag_in;
   logic [7:0] version_ff, version_in;
   logic [27:0] size_ff, size_in;
   logic [LIM_BITS-1:0] lim_ff, lim_in;
   logic found_ff, found_in;
   logic [23:0] header_ff, header_in;
   logic hdr_match;
   logic in_scan;

   // window holds bytes p-4..p-1; byte p exists, so a header there may count
   assign in_scan = CMP_BITS'(pos_ff) >= CMP_BITS'(lim_ff);
   assign hdr_match = (window_ff[31:24] == SYNC_BYTE) && (window_ff[23:21] == SYNC_TOP)
                      && (window_ff[18:17] == LAYER_III_CODE);

   always_comb begin
      window_in = {window_ff[23:0], data_byte};
      pos_in = (pos_ff != '1) ? pos_ff + COUNT_BITS'(1) : pos_ff;
      tag_in = tag_ff;
      version_in = version_ff;
      size_in = size_ff;
      lim_in = lim_ff;
      found_in = found_ff;
      header_in = header_ff;

      if (!found_ff && in_scan && hdr_match) begin
         found_in = 1'b1;
         header_in = window_ff[23:0];
      end
      if (pos_ff == COUNT_BITS'(POS_MAGIC_END) && window_in[23:0] == ID3_MAGIC) begin
         tag_in = 1'b1;
         lim_in = LIM_BITS'(TAG_HDR_LEN + WIN_LEN);
      end
      if (tag_ff && pos_ff == COUNT_BITS'(POS_VERSION))
         version_in = data_byte;
      if (tag_ff && pos_ff >= COUNT_BITS'(POS_SIZE_FIRST)
          && pos_ff <= COUNT_BITS'(POS_SIZE_LAST))
         size_in = {size_ff[20:0], data_byte[6:0]};
      if (tag_ff && pos_ff == COUNT_BITS'(POS_SIZE_LAST))
         lim_in = LIM_BITS'(size_in) + LIM_BITS'(TAG_HDR_LEN + WIN_LEN);

      push = accept && last_byte;
      rec.call_ok = pos_in >= COUNT_BITS'(MIN_LEN);
      rec.has_tag = tag_in;
      rec.tag_version = version_in;
      rec.tag_size = size_in;
      rec.frame_found = found_in;
      rec.header = header_in;
      rec.file_length = 32'(pos_in);
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && last_byte)) begin
         // start a fresh file
         pos_ff <= '0;
         window_ff <= '0;
         tag_ff <= 1'b0;
         version_ff <= '0;
         size_ff <= '0;
         lim_ff <= LIM_BITS'(WIN_LEN);
         found_ff <= 1'b0;
         header_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         window_ff <= window_in;
         tag_ff <= tag_in;
         version_ff <= version_in;
         size_ff <= size_in;
         lim_ff <= lim_in;
         found_ff <= found_in;
         header_ff <= header_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/mffhf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mffhf_queue (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  wire mffhf_pkg::summary_type rec_in,
   input  wire logic pop,
   output mffhf_pkg::summary_type rec_out,
   output mffhf_pkg::queue_status_type status
);
   import mffhf_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   summary_type slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ff, rd_ff;
   logic [PTR_BITS:0] count_ff;
   logic do_push, do_pop;

   assign status.full = count_ff == (PTR_BITS+1)'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push = push && !status.full;
   assign do_pop = pop && !status.empty;
   assign rec_out = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push)
         slot_ff[wr_ff] <= rec_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push)
            wr_ff <= (wr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_BITS'(1);
         if (do_pop)
            rd_ff <= (rd_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_BITS'(1);
         if (do_push && !do_pop)
            count_ff <= count_ff + (PTR_BITS+1)'(1);
         else if (do_pop && !do_push)
            count_ff <= count_ff - (PTR_BITS+1)'(1);
      end
   end

endmodule

`default_nettype wire

FILE: hdl/mffhf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mffhf_back (
   input  wire logic clock,
   input  wire logic reset,
   input  wire mffhf_pkg::summary_type head,
   input  wire mffhf_pkg::queue_status_type q_status,
   output logic pop,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic rsp_call_ok,
   output logic rsp_has_tag,
   output logic [7:0] rsp_tag_version,
   output logic [27:0] rsp_tag_size,
   output logic rsp_frame_found,
   output logic [1:0] rsp_audio_version,
   output logic [1:0] rsp_layer_number,
   output logic [8:0] rsp_bitrate_kbps,
   output logic [15:0] rsp_sample_rate_hz,
   output logic [1:0] rsp_stereo_mode,
   output logic [31:0] rsp_file_length
);
   import mffhf_pkg::*;

   logic valid_ff;
   logic ok_ff, tag_ff, ff_ff;
   logic [7:0] version_ff;
   logic [27:0] size_ff;
   logic [1:0] mpeg_ff, layer_ff, chan_ff;
   logic [8:0] kbps_ff;
   logic [15:0] rate_ff;
   logic [31:0] len_ff;
   logic tag_in, ff_in;

   // advance when the output register is free or being taken
   assign pop = !q_status.empty && (!valid_ff || rsp_ready);
   assign tag_in = head.call_ok && head.has_tag;
   assign ff_in = head.call_ok && head.frame_found;

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else if (pop)
         valid_ff <= 1'b1;
      else if (rsp_ready)
         valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         ok_ff <= head.call_ok;
         tag_ff <= tag_in;
         version_ff <= tag_in ? head.tag_version : '0;
         size_ff <= tag_in ? head.tag_size : '0;
         ff_ff <= ff_in;
         mpeg_ff <= !ff_in ? 2'd0 : (head.header[20:19] == MPEG1_CODE) ? 2'd1 : 2'd2;
         layer_ff <= ff_in ? 2'd3 : 2'd0;
         kbps_ff <= ff_in ? kbps_lookup(head.header[15:12]) : '0;
         rate_ff <= ff_in ? rate_lookup(head.header[11:10]) : '0;
         chan_ff <= ff_in ? head.header[7:6] : '0;
         len_ff <= head.file_length;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_call_ok = ok_ff;
   assign rsp_has_tag = tag_ff;
   assign rsp_tag_version = version_ff;
   assign rsp_tag_size = size_ff;
   assign rsp_frame_found = ff_ff;
   assign rsp_audio_version = mpeg_ff;
   assign rsp_layer_number = layer_ff;
   assign rsp_bitrate_kbps = kbps_ff;
   assign rsp_sample_rate_hz = rate_ff;
   assign rsp_stereo_mode = chan_ff;
   assign rsp_file_length = len_ff;

endmodule

`default_nettype wire

FILE: hdl/mp3_first_frame_header_finder.sv
`timescale 1ns / 1ps
`default_nettype none

// Finds the first MPEG layer III frame header of a byte stream, one file at a time.
// Input channel (req_): one file byte per word; req_last_byte marks the file's
// final byte, and the next word starts a new file. A leading ID3v2 tag is parsed
// (version and synchsafe size) and skipped before the header search starts.
// Result channel (rsp_): one summary word per file, sent after its last byte.
// Throughput: one byte per cycle while req_ready is high (the queue has room).
// The summary enters the two-entry queue at the edge that accepts the last
// byte, then is decoded into the output register, which drives rsp_valid,
// once that register is free or its word is being taken.
// When the receiver stalls, up to two summaries wait in the queue behind the
// one held at the output; bytes keep flowing until the queue is full, then
// req_ready drops until a summary is taken.
// Reset clears the byte count, tag and header state, empties the queue and
// drops rsp_valid; the first byte after reset starts a new file.
module mp3_first_frame_header_finder (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic req_last_byte,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic rsp_call_ok,
   output logic rsp_has_tag,
   output logic [7:0] rsp_tag_version,
   output logic [27:0] rsp_tag_size,
   output logic rsp_frame_found,
   output logic [1:0] rsp_audio_version,
   output logic [1:0] rsp_layer_number,
   output logic [8:0] rsp_bitrate_kbps,
   output logic [15:0] rsp_sample_rate_hz,
   output logic [1:0] rsp_stereo_mode,
   output logic [31:0] rsp_file_length
);
   import mffhf_pkg::*;

   logic accept;
   logic push;
   logic pop;
   summary_type front_rec;
   summary_type head_rec;
   queue_status_type q_status;

   // hold off bytes only while the summary queue has no room
   assign req_ready = !q_status.full;
   assign accept = req_valid && req_ready;

   mffhf_front u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .data_byte(req_data_byte),
      .last_byte(req_last_byte),
      .push(push),
      .rec(front_rec)
   );

   mffhf_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .rec_in(front_rec),
      .pop(pop),
      .rec_out(head_rec),
      .status(q_status)
   );

   mffhf_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head_rec),
      .q_status(q_status),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_call_ok(rsp_call_ok),
      .rsp_has_tag(rsp_has_tag),
      .rsp_tag_version(rsp_tag_version),
      .rsp_tag_size(rsp_tag_size),
      .rsp_frame_found(rsp_frame_found),
      .rsp_audio_version(rsp_audio_version),
      .rsp_layer_number(rsp_layer_number),
      .rsp_bitrate_kbps(rsp_bitrate_kbps),
      .rsp_sample_rate_hz(rsp_sample_rate_hz),
      .rsp_stereo_mode(rsp_stereo_mode),
      .rsp_file_length(rsp_file_length)
   );

   // the output register is empty right after reset
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // a found frame always comes with a full-length file and layer III
   a_frame_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_found |-> rsp_call_ok && rsp_layer_number == 2'd3
                                       && rsp_audio_version != 2'd0)
      else $error("frame summary fields inconsistent");

   // a short file reports nothing but its length
   a_short_file: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_call_ok |-> rsp_file_length < 32'd10 && !rsp_has_tag
                                    && !rsp_frame_found)
      else $error("short file summary not cleared");

   // no summary is pushed while the queue is full
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push)
      else $error("summary pushed into a full queue");

endmodule

`default_nettype wire

FILE: sim/mp3_first_frame_header_finder_tb.sv
`timescale 1ns / 1ps

module mp3_first_frame_header_finder_tb;

   import mffhf_pkg::*;

   localparam int CNT_W = COUNT_BITS;
   localparam int TARGET_BYTES = 830;     // directed rows plus about 800 random bytes
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES = 150;
   localparam int IDLE_PCT = 24;
   localparam int NO_KNOWN = -1;

   localparam logic [7:0] SYNC_MARK = 8'hFF;
   localparam logic [1:0] LAYER3_BITS = 2'b01;
   localparam logic [23:0] TAG_MAGIC = "ID3";
   localparam int TAG_SIZE_FIRST = 6;
   localparam int TAG_SIZE_LAST = 9;
   localparam int TAG_HEADER_BYTES = 10;

   localparam logic [8:0] KBPS_BY_INDEX [16] = '{
      9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0
   };
   localparam logic [15:0] HZ_BY_INDEX [4] = '{16'd44100, 16'd48000, 16'd32000, 16'd0};

   typedef struct packed {
      logic call_ok;
      logic has_tag;
      logic [7:0] tag_version;
      logic [27:0] tag_size;
      logic frame_found;
      logic [1:0] audio_version;
      logic [1:0] layer_number;
      logic [8:0] bitrate_kbps;
      logic [15:0] sample_rate_hz;
      logic [1:0] stereo_mode;
      logic [31:0] file_length;
   } file_summary_type;

   typedef struct packed {
      logic [7:0] data;
      logic last;
      int known;      // index into KNOWN_SUMMARY, or NO_KNOWN to use the scanner model
   } stim_row_type;

   // summaries that can be read straight off the byte rows below
   localparam file_summary_type KNOWN_SUMMARY [4] = '{
      // one-byte file: too short, everything zero but the length
      '{1'b0, 1'b0, 8'h00, 28'h0, 1'b0, 2'd0, 2'd0, 9'd0, 16'd0, 2'd0, 32'd1},
      // bare tag header with the largest size: tag runs past the end, no frame
      '{1'b1, 1'b1, 8'hFF, 28'hFFFFFFF, 1'b0, 2'd0, 2'd0, 9'd0, 16'd0, 2'd0, 32'd10},
      // MPEG-1 layer III header at offset zero: 128 kbps, 44.1 kHz, mono
      '{1'b1, 1'b0, 8'h00, 28'h0, 1'b1, 2'd1, 2'd3, 9'd128, 16'd44100, 2'd3, 32'd10},
      // short file that holds a valid header: still all zero but the length
      '{1'b0, 1'b0, 8'h00, 28'h0, 1'b0, 2'd0, 2'd0, 9'd0, 16'd0, 2'd0, 32'd5}
   };

   localparam stim_row_type DIRECTED [26] = '{
      '{8'h00, 1'b1, 0},
      '{8'h49, 1'b0, NO_KNOWN}, '{8'h44, 1'b0, NO_KNOWN}, '{8'h33, 1'b0, NO_KNOWN},
      '{8'hFF, 1'b0, NO_KNOWN}, '{8'h00, 1'b0, NO_KNOWN}, '{8'h00, 1'b0, NO_KNOWN},
      '{8'h7F, 1'b0, NO_KNOWN}, '{8'h7F, 1'b0, NO_KNOWN}, '{8'h7F, 1'b0, NO_KNOWN},
      '{8'h7F, 1'b1, 1},
      '{8'hFF, 1'b0, NO_KNOWN}, '{8'hFB, 1'b0, NO_KNOWN}, '{8'h90, 1'b0, NO_KNOWN},
      '{8'hC4, 1'b0, NO_KNOWN}, '{8'h00, 1'b0, NO_KNOWN}, '{8'h00, 1'b0, NO_KNOWN},
      '{8'h00, 1'b0, NO_KNOWN}, '{8'h00, 1'b0, NO_KNOWN}, '{8'h00, 1'b0, NO_KNOWN},
      '{8'hFF, 1'b1, 2},
      '{8'hFF, 1'b0, NO_KNOWN}, '{8'hE3, 1'b0, NO_KNOWN}, '{8'hEC, 1'b0, NO_KNOWN},
      '{8'h40, 1'b0, NO_KNOWN}, '{8'h11, 1'b1, 3}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic req_last_byte = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_call_ok;
   logic rsp_has_tag;
   logic [7:0] rsp_tag_version;
   logic [27:0] rsp_tag_size;
   logic rsp_frame_found;
   logic [1:0] rsp_audio_version;
   logic [1:0] rsp_layer_number;
   logic [8:0] rsp_bitrate_kbps;
   logic [15:0] rsp_sample_rate_hz;
   logic [1:0] rsp_stereo_mode;
   logic [31:0] rsp_file_length;

   // scanner model state, one file at a time
   logic [CNT_W-1:0] byte_count = '0;
   logic [31:0] recent_bytes = '0;
   logic tag_on = 1'b0;
   logic [7:0] tag_ver = '0;
   logic [27:0] tag_len = '0;
   logic [63:0] scan_from = '0;
   logic hdr_seen = 1'b0;
   logic [31:0] hdr_bytes = '0;

   file_summary_type summary_q [$];
   logic [7:0] file_buf [$];
   int mismatches = 0;
   int bytes_sent = 0;
   int cycle_count = 0;
   int send_idle_pct = IDLE_PCT;
   int rsp_idle_pct = IDLE_PCT;
   int hold_left = 0;
   bit hold_start = 1'b0;

   mp3_first_frame_header_finder dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_call_ok(rsp_call_ok),
      .rsp_has_tag(rsp_has_tag),
      .rsp_tag_version(rsp_tag_version),
      .rsp_tag_size(rsp_tag_size),
      .rsp_frame_found(rsp_frame_found),
      .rsp_audio_version(rsp_audio_version),
      .rsp_layer_number(rsp_layer_number),
      .rsp_bitrate_kbps(rsp_bitrate_kbps),
      .rsp_sample_rate_hz(rsp_sample_rate_hz),
      .rsp_stereo_mode(rsp_stereo_mode),
      .rsp_file_length(rsp_file_length)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Advance the scanner model by one byte. Return 1 with the file summary on the
   // last byte of a file, and clear the per-file state there.
   function automatic bit scan_byte(input logic [7:0] b, input logic fin,
                                    output file_summary_type s);
      logic [63:0] pos;
      logic [7:0] h1;
      logic [7:0] h2;
      logic [7:0] h3;
      logic ok;
      logic ff;
      pos = 64'(byte_count);
      s = '0;
      // the window holds the four bytes before this one, so a header there
      // already has a byte behind it
      if (!hdr_seen && pos >= 4 && pos - 4 >= scan_from) begin
         h1 = recent_bytes[23:16];
         if (recent_bytes[31:24] == SYNC_MARK && h1[7:5] == 3'b111 &&
             h1[2:1] == LAYER3_BITS) begin
            hdr_seen = 1'b1;
            hdr_bytes = recent_bytes;
         end
      end
      recent_bytes = {recent_bytes[23:0], b};
      if (pos == 2 && recent_bytes[23:0] == TAG_MAGIC) begin
         tag_on = 1'b1;
         scan_from = TAG_HEADER_BYTES;
      end
      if (tag_on && pos == 3)
         tag_ver = b;
      if (tag_on && pos >= TAG_SIZE_FIRST && pos <= TAG_SIZE_LAST)
         tag_len = {tag_len[20:0], b[6:0]};
      if (tag_on && pos == TAG_SIZE_LAST)
         scan_from = TAG_HEADER_BYTES + 64'(tag_len);
      // saturate rather than wrap
      if (byte_count != '1)
         byte_count++;
      if (!fin)
         return 1'b0;

      ok = (64'(byte_count) >= 10);
      ff = ok && hdr_seen;
      h1 = hdr_bytes[23:16];
      h2 = hdr_bytes[15:8];
      h3 = hdr_bytes[7:0];
      s.call_ok = ok;
      s.has_tag = ok && tag_on;
      s.tag_version = s.has_tag ? tag_ver : 8'h00;
      s.tag_size = s.has_tag ? tag_len : 28'h0;
      s.frame_found = ff;
      s.audio_version = ff ? ((h1[4:3] == 2'b11) ? 2'd1 : 2'd2) : 2'd0;
      s.layer_number = ff ? 2'd3 : 2'd0;
      s.bitrate_kbps = ff ? KBPS_BY_INDEX[h2[7:4]] : 9'd0;
      s.sample_rate_hz = ff ? HZ_BY_INDEX[h2[3:2]] : 16'd0;
      s.stereo_mode = ff ? h3[7:6] : 2'd0;
      s.file_length = 32'(byte_count);

      byte_count = '0;
      recent_bytes = '0;
      tag_on = 1'b0;
      tag_ver = '0;
      tag_len = '0;
      scan_from = '0;
      hdr_seen = 1'b0;
      hdr_bytes = '0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // Offer one byte word, with random idle cycles ahead of it, and hold it until
   // it is taken. Valid stays high into the next word unless that word idles first.
   task automatic send_byte(input logic [7:0] b, input logic fin, input int known);
      file_summary_type s;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= fin;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (scan_byte(b, fin, s))
         summary_q.push_back((known == NO_KNOWN) ? s : KNOWN_SUMMARY[known]);
   endtask

   task automatic send_file();
      foreach (file_buf[i])
         send_byte(file_buf[i], i == file_buf.size() - 1, NO_KNOWN);
   endtask

   // Drop valid and hold until every summary owed so far has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (summary_q.size() != 0)
         @(posedge clock);
   endtask

   // bytes rich in sync marks so that partial and false headers turn up often
   function automatic logic [7:0] noisy_byte();
      return ($urandom_range(3) == 0) ? SYNC_MARK : 8'($urandom);
   endfunction

   task automatic push_header(input logic [1:0] layer);
      file_buf.push_back(SYNC_MARK);
      file_buf.push_back({3'b111, 2'($urandom), layer, 1'($urandom)});
      file_buf.push_back(8'($urandom));
      file_buf.push_back(8'($urandom));
   endtask

   task automatic push_tag_start();
      file_buf.push_back(TAG_MAGIC[23:16]);
      file_buf.push_back(TAG_MAGIC[15:8]);
      file_buf.push_back(TAG_MAGIC[7:0]);
      file_buf.push_back(8'($urandom));    // version
      file_buf.push_back(8'($urandom));    // revision
      file_buf.push_back(8'($urandom));    // flags
   endtask

   // Build one random file into file_buf. Most files are well formed: an optional
   // small tag, some junk, a layer III header and a tail. The rest are noise and
   // broken cases.
   task automatic make_file();
      int kind;
      int body;
      logic [1:0] bad_layer;
      file_buf.delete();
      kind = $urandom_range(99);
      if (kind < 65) begin
         if ($urandom_range(1)) begin
            body = $urandom_range(12);
            push_tag_start();
            // size bytes carry a random top bit that must be masked off
            repeat (3) file_buf.push_back({1'($urandom), 7'd0});
            file_buf.push_back({1'($urandom), 7'(body)});
            // sometimes hide a header inside the tag body, where it must not count
            if (body >= 5 && $urandom_range(1)) begin
               push_header(LAYER3_BITS);
               body -= 4;
            end
            repeat (body) file_buf.push_back(noisy_byte());
         end
         repeat ($urandom_range(6)) file_buf.push_back(noisy_byte());
         push_header(LAYER3_BITS);
         repeat ($urandom_range(1, 8)) file_buf.push_back(noisy_byte());
      end else begin
         case (kind % 5)
            0: repeat ($urandom_range(1, 24)) file_buf.push_back(noisy_byte());
            1: begin
               // sync mark with the wrong layer, or without the top three bits
               repeat ($urandom_range(4)) file_buf.push_back(8'($urandom));
               bad_layer = 2'($urandom_range(2));
               if (bad_layer == LAYER3_BITS)
                  bad_layer = 2'b11;
               file_buf.push_back(SYNC_MARK);
               if ($urandom_range(1))
                  file_buf.push_back({3'b111, 2'($urandom), bad_layer, 1'($urandom)});
               else
                  file_buf.push_back({3'($urandom_range(6)), 5'($urandom)});
               repeat ($urandom_range(4, 12)) file_buf.push_back(8'($urandom));
            end
            2: begin
               // header as the last four bytes: no byte follows, so it misses
               repeat ($urandom_range(6, 10)) file_buf.push_back(8'($urandom));
               push_header(LAYER3_BITS);
            end
            3: begin
               // tag size fully random, mostly far past the end of the file
               push_tag_start();
               repeat (4) file_buf.push_back(8'($urandom));
               push_header(LAYER3_BITS);
               repeat ($urandom_range(1, 10)) file_buf.push_back(noisy_byte());
            end
            default: begin
               // shorter than ten bytes, opening with the magic or a header
               if ($urandom_range(1))
                  push_tag_start();
               else
                  push_header(LAYER3_BITS);
               repeat ($urandom_range(3)) file_buf.push_back(noisy_byte());
            end
         endcase
      end
   endtask

   // Result side: take words with random stalls, or hold off entirely for a long
   // stretch when the stimulus asks for it, and check each taken word against
   // the oldest predicted summary.
   always @(posedge clock) begin
      file_summary_type got;
      file_summary_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_call_ok, rsp_has_tag, rsp_tag_version, rsp_tag_size, rsp_frame_found,
                 rsp_audio_version, rsp_layer_number, rsp_bitrate_kbps, rsp_sample_rate_hz,
                 rsp_stereo_mode, rsp_file_length};
         if (summary_q.size() == 0) begin
            report_mismatch("summary word with no file pending");
         end else begin
            want = summary_q.pop_front();
            check_field("call_ok", 32'(got.call_ok), 32'(want.call_ok));
            check_field("has_tag", 32'(got.has_tag), 32'(want.has_tag));
            check_field("tag_version", 32'(got.tag_version), 32'(want.tag_version));
            check_field("tag_size", 32'(got.tag_size), 32'(want.tag_size));
            check_field("frame_found", 32'(got.frame_found), 32'(want.frame_found));
            check_field("audio_version", 32'(got.audio_version),
                        32'(want.audio_version));
            check_field("layer_number", 32'(got.layer_number), 32'(want.layer_number));
            check_field("bitrate_kbps", 32'(got.bitrate_kbps), 32'(want.bitrate_kbps));
            check_field("sample_rate_hz", 32'(got.sample_rate_hz),
                        32'(want.sample_rate_hz));
            check_field("stereo_mode", 32'(got.stereo_mode), 32'(want.stereo_mode));
            check_field("file_length", got.file_length, want.file_length);
         end
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (hold_start) begin
         hold_start = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Stop a hung run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int files_sent;
      files_sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table: short files, largest tag, plain header
      foreach (DIRECTED[i])
         send_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].known);
      drain_results();

      while (bytes_sent < TARGET_BYTES) begin
         files_sent++;
         if (files_sent == 10) begin
            // block the result side and keep pushing tiny files: the summary
            // queue fills and req_ready has to drop
            hold_start = 1'b1;
            repeat (12) begin
               file_buf.delete();
               repeat ($urandom_range(1, 3)) file_buf.push_back(noisy_byte());
               send_file();
            end
            drain_results();
         end
         // a stretch with both sides running flat out
         if (files_sent == 25) begin
            send_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if (files_sent == 40) begin
            send_idle_pct = IDLE_PCT;
            rsp_idle_pct = IDLE_PCT;
         end
         make_file();
         send_file();
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/mffhf_pkg.sv
hdl/mffhf_front.sv
hdl/mffhf_queue.sv
hdl/mffhf_back.sv
hdl/mp3_first_frame_header_finder.sv
sim/mp3_first_frame_header_finder_tb.sv
